FILE: rtl/core/spat_pkg.sv
// shared types and codes for the segment and page address translator
// no dependencies; imported by every module in rtl/core
package spat_pkg;

	localparam int SlotW   = 10;
	localparam int WordW   = 64;
	localparam int AddrW   = 32;
	localparam int SelW    = 16;
	localparam int ActW    = 3;
	localparam int CauseW  = 4;
	localparam int DescCntW = 7;
	localparam int PageCntW = 11;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 11;
	localparam int DescIdxW = 13;

	localparam logic [ActW-1:0] ACT_TRANSLATE  = 3'd0;
	localparam logic [ActW-1:0] ACT_LOAD_GLOBAL = 3'd1;
	localparam logic [ActW-1:0] ACT_LOAD_LOCAL = 3'd2;
	localparam logic [ActW-1:0] ACT_LOAD_DIR   = 3'd3;
	localparam logic [ActW-1:0] ACT_LOAD_TABLE = 3'd4;

	localparam logic [CauseW-1:0] FLT_NONE       = 4'd0;
	localparam logic [CauseW-1:0] FLT_NULL_SEL   = 4'd1;
	localparam logic [CauseW-1:0] FLT_DESC_RANGE = 4'd2;
	localparam logic [CauseW-1:0] FLT_SEG_ABSENT = 4'd3;
	localparam logic [CauseW-1:0] FLT_LIMIT      = 4'd4;
	localparam logic [CauseW-1:0] FLT_DIR_RANGE  = 4'd5;
	localparam logic [CauseW-1:0] FLT_DIR_ABSENT = 4'd6;
	localparam logic [CauseW-1:0] FLT_TBL_RANGE  = 4'd7;
	localparam logic [CauseW-1:0] FLT_PAGE_ABSENT = 4'd8;

	localparam logic [CfgIdxW-1:0] CFG_GLOBAL_COUNT = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LOCAL_COUNT  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_DIR_COUNT    = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_TABLE_COUNT  = 2'd3;

	typedef struct packed {
		logic             we;
		logic             is_local;
		logic [SlotW-1:0] slot;
		logic [WordW-1:0] word;
	} desc_wr_t;

	typedef struct packed {
		logic             dir_we;
		logic             tbl_we;
		logic [SlotW-1:0] slot;
		logic             dir_bit;
		logic [31:0]      tbl_word;
	} page_wr_t;

endpackage

FILE: rtl/core/segment_page_address_translator_unit.sv
// segment and page address translator, top level
// done and the results come from the result register behind two pipeline stages (stage 1,
// stage 2); a new item is not accepted while busy is high, that is while the last item is in
// stage 1, so items do not overlap there; busy is high for one cycle per item
// reset clears the count registers and the pipeline; memories hold junk until loaded
// results cannot be stalled: done marks each beat for one cycle
module segment_page_address_translator_unit import spat_pkg::*; #(
	parameter int DESC_DEPTH   = 64,
	parameter int PAGE_ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ActW-1:0]     action,
	input  logic [SlotW-1:0]    slot,
	input  logic [WordW-1:0]    entry_word,
	input  logic [AddrW-1:0]    logical_addr,
	input  logic [SelW-1:0]     seg_selector,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output logic                done,
	output logic [AddrW-1:0]    physical_addr,
	output logic [CauseW-1:0]   fault_cause
);

	localparam logic [DescIdxW:0]  DescDepthW = (DescIdxW+1)'(DESC_DEPTH);
	localparam logic [PageCntW-1:0] PageDepthW = PageCntW'(PAGE_ENTRIES);

	logic accept;

	logic [DescCntW-1:0] global_count_q;
	logic [DescCntW-1:0] local_count_q;
	logic [PageCntW-1:0] dir_count_q;
	logic [PageCntW-1:0] table_count_q;

	logic               vld_s1;
	logic [ActW-1:0]    act_s1;
	logic [AddrW-1:0]   offset_s1;
	logic [SelW-1:0]    sel_s1;

	logic               vld_s2;
	logic               xlate_s2;
	logic [CauseW-1:0]  fault_s2;
	logic               tbl_range_s2;
	logic [11:0]        lin_lo_s2;

	logic               done_q;
	logic [AddrW-1:0]   phys_q;
	logic [CauseW-1:0]  cause_q;
	logic [AddrW-1:0]   phys_nxt;
	logic [CauseW-1:0]  cause_nxt;

	desc_wr_t           desc_wr;
	page_wr_t           page_wr;
	logic [WordW-1:0]   desc;
	logic               dir_present;
	logic [31:0]        tbl_entry;

	logic [DescIdxW:0]  slot_ext;
	logic [DescIdxW:0]  desc_cnt;
	logic [DescIdxW:0]  desc_cnt_eff;
	logic [PageCntW-1:0] dir_cnt_eff;
	logic [PageCntW-1:0] tbl_cnt_eff;
	logic [19:0]        limit_raw;
	logic [AddrW-1:0]   limit;
	logic [AddrW-1:0]   base;
	logic [AddrW-1:0]   lin;
	logic [CauseW-1:0]  fault_s1;

	assign accept    = start && !busy;
	assign busy      = vld_s1;
	assign cfg_ready = 1'b1;

	// load beats write the stores at the accepting edge
	assign slot_ext = {{(DescIdxW+1-SlotW){1'b0}}, slot};

	always_comb begin
		desc_wr.we       = accept && ((action == ACT_LOAD_GLOBAL) || (action == ACT_LOAD_LOCAL))
			&& (slot_ext < DescDepthW);
		desc_wr.is_local = (action == ACT_LOAD_LOCAL);
		desc_wr.slot     = slot;
		desc_wr.word     = entry_word;

		page_wr.dir_we   = accept && (action == ACT_LOAD_DIR)
			&& ({1'b0, slot} < PageDepthW);
		page_wr.tbl_we   = accept && (action == ACT_LOAD_TABLE)
			&& ({1'b0, slot} < PageDepthW);
		page_wr.slot     = slot;
		page_wr.dir_bit  = entry_word[0];
		page_wr.tbl_word = entry_word[31:0];
	end

	spat_desc_mem #(
		.DESC_DEPTH(DESC_DEPTH)
	) u_desc_mem (
		.clk     (clk),
		.wr      (desc_wr),
		.rd_en   (accept),
		.rd_local(seg_selector[2]),
		.rd_idx  (seg_selector[15:3]),
		.rd_data (desc)
	);

	spat_page_mem #(
		.PAGE_ENTRIES(PAGE_ENTRIES)
	) u_page_mem (
		.clk        (clk),
		.wr         (page_wr),
		.rd_en      (vld_s1),
		.dir_idx    (lin[31:22]),
		.tbl_idx    (lin[21:12]),
		.dir_present(dir_present),
		.tbl_entry  (tbl_entry)
	);

	// count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_count_q <= '0;
			local_count_q  <= '0;
			dir_count_q    <= '0;
			table_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GLOBAL_COUNT: global_count_q <= cfg_data[DescCntW-1:0];
				CFG_LOCAL_COUNT:  local_count_q  <= cfg_data[DescCntW-1:0];
				CFG_DIR_COUNT:    dir_count_q    <= cfg_data;
				CFG_TABLE_COUNT:  table_count_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage 1: descriptor checks, directory range check and linear address
	always_comb begin
		desc_cnt     = {{(DescIdxW+1-DescCntW){1'b0}},
			(sel_s1[2] ? local_count_q : global_count_q)};
		desc_cnt_eff = (desc_cnt > DescDepthW) ? DescDepthW : desc_cnt;
		dir_cnt_eff  = (dir_count_q > PageDepthW) ? PageDepthW : dir_count_q;
		tbl_cnt_eff  = (table_count_q > PageDepthW) ? PageDepthW : table_count_q;

		limit_raw = {desc[51:48], desc[15:0]};
		limit     = desc[55] ? {limit_raw, 12'hFFF} : {12'h000, limit_raw};
		base      = {desc[63:56], desc[39:16]};
		lin       = offset_s1 + base;

		if (sel_s1[15:2] == '0) begin
			fault_s1 = FLT_NULL_SEL;
		end else if ({1'b0, sel_s1[15:3]} >= desc_cnt_eff) begin
			fault_s1 = FLT_DESC_RANGE;
		end else if (!desc[47]) begin
			fault_s1 = FLT_SEG_ABSENT;
		end else if (offset_s1 > limit) begin
			fault_s1 = FLT_LIMIT;
		end else if ({1'b0, lin[31:22]} >= dir_cnt_eff) begin
			fault_s1 = FLT_DIR_RANGE;
		end else begin
			fault_s1 = FLT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= action;
			offset_s1 <= logical_addr;
			sel_s1    <= seg_selector;
		end
		if (vld_s1) begin
			xlate_s2     <= (act_s1 == ACT_TRANSLATE);
			fault_s2     <= fault_s1;
			tbl_range_s2 <= ({1'b0, lin[21:12]} >= tbl_cnt_eff);
			lin_lo_s2    <= lin[11:0];
		end
	end

	// stage 2: directory and page checks, result register
	always_comb begin
		phys_nxt  = '0;
		cause_nxt = FLT_NONE;
		if (xlate_s2) begin
			if (fault_s2 != FLT_NONE) begin
				cause_nxt = fault_s2;
			end else if (!dir_present) begin
				cause_nxt = FLT_DIR_ABSENT;
			end else if (tbl_range_s2) begin
				cause_nxt = FLT_TBL_RANGE;
			end else if (!tbl_entry[0]) begin
				cause_nxt = FLT_PAGE_ABSENT;
			end else begin
				phys_nxt = {tbl_entry[31:12], lin_lo_s2};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			phys_q  <= phys_nxt;
			cause_q <= cause_nxt;
		end
	end

	assign done          = done_q;
	assign physical_addr = phys_q;
	assign fault_cause   = cause_q;

endmodule

FILE: rtl/core/spat_desc_mem.sv
// descriptor memory: global and local tables in one synchronous ram
// one write port, one registered read port; uses spat_pkg
module spat_desc_mem import spat_pkg::*; #(
	parameter int DESC_DEPTH = 64
) (
	input  logic                clk,
	input  desc_wr_t            wr,
	input  logic                rd_en,
	input  logic                rd_local,
	input  logic [DescIdxW-1:0] rd_idx,
	output logic [WordW-1:0]    rd_data
);

	localparam int DAW = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;

	logic [WordW-1:0] mem [0:2*(2**DAW)-1];

	logic [DescIdxW-1:0] wr_idx;
	logic [DAW:0]        wr_addr;
	logic [DAW:0]        rd_addr;

	assign wr_idx  = {{(DescIdxW-SlotW){1'b0}}, wr.slot};
	assign wr_addr = {wr.is_local, wr_idx[DAW-1:0]};
	assign rd_addr = {rd_local, rd_idx[DAW-1:0]};

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr_addr] <= wr.word;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/spat_page_mem.sv
// page memory: directory present bit and table entry share one row
// masked write, two registered read ports (directory and table index); uses spat_pkg
module spat_page_mem import spat_pkg::*; #(
	parameter int PAGE_ENTRIES = 1024
) (
	input  logic             clk,
	input  page_wr_t         wr,
	input  logic             rd_en,
	input  logic [SlotW-1:0] dir_idx,
	input  logic [SlotW-1:0] tbl_idx,
	output logic             dir_present,
	output logic [31:0]      tbl_entry
);

	localparam int PAW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;

	// bit 32 is the directory present bit, bits 31:0 the table entry
	logic [32:0] mem [0:(2**PAW)-1];

	logic [PAW-1:0] wr_addr;

	assign wr_addr = wr.slot[PAW-1:0];

	always_ff @(posedge clk) begin
		if (wr.dir_we) begin
			mem[wr_addr][32] <= wr.dir_bit;
		end
		if (wr.tbl_we) begin
			mem[wr_addr][31:0] <= wr.tbl_word;
		end
		if (rd_en) begin
			dir_present <= mem[dir_idx[PAW-1:0]][32];
			tbl_entry   <= mem[tbl_idx[PAW-1:0]][31:0];
		end
	end

endmodule
